/* rtl/pds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Types, constants, clock ROM and microprogram of the PLL divider search.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int TGT_W       = 20;
  localparam int REF_W       = 18;
  localparam int DREF_W      = 3;
  localparam int MULT_W      = 8;
  localparam int DOUT_W      = 7;

  localparam int TOL_KHZ        = 1000;
  localparam int DOUT_MIN       = 6;
  localparam int DOUT_END       = 64;
  localparam int DREF_MIN       = 3;
  localparam int DREF_END       = 6;
  localparam int MULT_END       = 161;
  localparam int MULT_LO_FACTOR = 12;
  localparam int MULT_HI_FACTOR = 32;
  localparam int ROM_SIZE       = 25;
  localparam int REF_RESET      = 100000;

  localparam int DREF_COUNT = DREF_END - DREF_MIN;
  localparam int DSEL_W     = $clog2(DREF_COUNT);
  localparam int DCNT_W     = $clog2(DOUT_END);
  localparam int ROM_IDX_W  = $clog2(ROM_SIZE);
  localparam int DIV_CNT_W  = $clog2(REF_W);
  localparam int BEST_W     = $clog2(TOL_KHZ + 1);
  localparam int LHS_W      = TGT_W + DCNT_W;
  localparam int ACC_W      = REF_W + $clog2(MULT_HI_FACTOR);
  localparam int REM_W      = DREF_W;

  typedef struct packed {
    logic [TGT_W-1:0]  khz;
    logic [DREF_W-1:0] dref;
    logic [MULT_W-1:0] mult;
    logic [DOUT_W-1:0] dout;
  } rom_entry_t;

  function automatic rom_entry_t rom_entry(input int unsigned k, d, m, o);
    rom_entry_t e;
    e.khz  = TGT_W'(k);
    e.dref = DREF_W'(d);
    e.mult = MULT_W'(m);
    e.dout = DOUT_W'(o);
    return e;
  endfunction

  function automatic rom_entry_t clock_rom(input logic [ROM_IDX_W-1:0] idx);
    rom_entry_t e;
    case (idx)
      5'd0:    e = rom_entry(148500, 3,  49, 11);
      5'd1:    e = rom_entry(174500, 3,  89, 17);
      5'd2:    e = rom_entry(181250, 4,  58,  8);
      5'd3:    e = rom_entry(146250, 5, 117, 16);
      5'd4:    e = rom_entry(135000, 4,  54, 10);
      5'd5:    e = rom_entry(108000, 5,  81, 15);
      5'd6:    e = rom_entry(106500, 4,  81, 19);
      5'd7:    e = rom_entry( 88750, 5,  71, 16);
      5'd8:    e = rom_entry( 83500, 5,  71, 17);
      5'd9:    e = rom_entry( 71000, 5,  71, 20);
      5'd10:   e = rom_entry( 74250, 3,  49, 22);
      5'd11:   e = rom_entry( 78750, 5,  63, 16);
      5'd12:   e = rom_entry( 75000, 4,  87, 29);
      5'd13:   e = rom_entry( 65000, 3,  39, 20);
      5'd14:   e = rom_entry( 51200, 5,  64, 25);
      5'd15:   e = rom_entry( 57284, 4,  55, 24);
      5'd16:   e = rom_entry( 49500, 5,  99, 40);
      5'd17:   e = rom_entry( 50000, 4,  88, 44);
      5'd18:   e = rom_entry( 40000, 3,  36, 30);
      5'd19:   e = rom_entry( 36000, 4,  72, 50);
      5'd20:   e = rom_entry( 31500, 5,  63, 40);
      5'd21:   e = rom_entry( 30240, 4,  75, 62);
      5'd22:   e = rom_entry( 27000, 4,  54, 50);
      5'd23:   e = rom_entry( 25175, 5, 107, 85);
      5'd24:   e = rom_entry( 25200, 5,  63, 50);
      default: e = rom_entry(0, 0, 0, 0);
    endcase
    return e;
  endfunction

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_ROM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_SAVE,
    OP_OUT_INIT,
    OP_LHS,
    OP_MULT_INIT,
    OP_CAND,
    OP_DREF_INC,
    OP_DOUT_INC,
    OP_FINISH,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_ROM_HIT,
    C_ROM_MORE,
    C_DIV_MORE,
    C_DSEL_MORE,
    C_ZERO,
    C_MULT_MORE,
    C_DOUT_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_ROM       = 4'd1;
  localparam step_t S_DIV_INIT  = 4'd2;
  localparam step_t S_DIV_STEP  = 4'd3;
  localparam step_t S_DIV_SAVE  = 4'd4;
  localparam step_t S_OUT_INIT  = 4'd5;
  localparam step_t S_LHS       = 4'd6;
  localparam step_t S_MULT_INIT = 4'd7;
  localparam step_t S_CAND      = 4'd8;
  localparam step_t S_DREF_NEXT = 4'd9;
  localparam step_t S_DOUT_NEXT = 4'd10;
  localparam step_t S_FINISH    = 4'd11;
  localparam step_t S_EMIT      = 4'd12;

  typedef struct packed {
    op_t   op;
    cond_t cond_a;
    step_t tgt_a;
    cond_t cond_b;
    step_t tgt_b;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic idle;
  } pds_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic rom_hit;
    logic rom_more;
    logic div_more;
    logic dsel_more;
    logic cand_zero;
    logic mult_more;
    logic dout_more;
    logic out_busy;
  } pds_status_t;

  function automatic uword_t uw(input op_t op, input cond_t ca, input step_t ta,
                                input cond_t cb, input step_t tb);
    uword_t w;
    w.op     = op;
    w.cond_a = ca;
    w.tgt_a  = ta;
    w.cond_b = cb;
    w.tgt_b  = tb;
    return w;
  endfunction

  // first matching jump wins, otherwise fall through to the next step
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_IDLE:      w = uw(OP_LOAD,      C_NO_IN,     S_IDLE,      C_NEVER,     S_IDLE);
      S_ROM:       w = uw(OP_ROM,       C_ROM_HIT,   S_EMIT,      C_ROM_MORE,  S_ROM);
      S_DIV_INIT:  w = uw(OP_DIV_INIT,  C_NEVER,     S_IDLE,      C_NEVER,     S_IDLE);
      S_DIV_STEP:  w = uw(OP_DIV_STEP,  C_DIV_MORE,  S_DIV_STEP,  C_NEVER,     S_IDLE);
      S_DIV_SAVE:  w = uw(OP_DIV_SAVE,  C_DSEL_MORE, S_DIV_STEP,  C_NEVER,     S_IDLE);
      S_OUT_INIT:  w = uw(OP_OUT_INIT,  C_NEVER,     S_IDLE,      C_NEVER,     S_IDLE);
      S_LHS:       w = uw(OP_LHS,       C_NEVER,     S_IDLE,      C_NEVER,     S_IDLE);
      S_MULT_INIT: w = uw(OP_MULT_INIT, C_NEVER,     S_IDLE,      C_NEVER,     S_IDLE);
      S_CAND:      w = uw(OP_CAND,      C_ZERO,      S_FINISH,    C_MULT_MORE, S_CAND);
      S_DREF_NEXT: w = uw(OP_DREF_INC,  C_DSEL_MORE, S_MULT_INIT, C_NEVER,     S_IDLE);
      S_DOUT_NEXT: w = uw(OP_DOUT_INC,  C_DOUT_MORE, S_LHS,       C_NEVER,     S_IDLE);
      S_FINISH:    w = uw(OP_FINISH,    C_NEVER,     S_IDLE,      C_NEVER,     S_IDLE);
      S_EMIT:      w = uw(OP_EMIT,      C_OUT_BUSY,  S_EMIT,      C_ALWAYS,    S_IDLE);
      default:     w = uw(OP_LOAD,      C_ALWAYS,    S_IDLE,      C_NEVER,     S_IDLE);
    endcase
    return w;
  endfunction

endpackage

/* rtl/pds_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_in_if / pds_out_if
// Valid/ready channels for requests and PLL settings.
// ----------------------------------------------------------------------------
interface pds_in_if import pds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TGT_W-1:0] target_clock_khz;

  modport source (output valid, output target_clock_khz, input ready);
  modport sink   (input valid, input target_clock_khz, output ready);
endinterface

interface pds_out_if import pds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [DREF_W-1:0] reference_divider;
  logic [MULT_W-1:0] feedback_multiplier;
  logic [DOUT_W-1:0] output_divider;

  modport source (output valid, output found, output reference_divider,
                  output feedback_multiplier, output output_divider, input ready);
  modport sink   (input valid, input found, input reference_divider,
                  input feedback_multiplier, input output_divider, output ready);
endinterface

/* rtl/pds_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_sequencer
// Step counter and microcode ROM with two conditional jumps per step.
// ----------------------------------------------------------------------------
module pds_sequencer import pds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pds_status_t status,
  output pds_ctrl_t   ctrl
);

  step_t  step_r;
  step_t  step_nxt;
  uword_t word;

  function automatic logic cond_met(input cond_t c, input pds_status_t st);
    logic r;
    case (c)
      C_NEVER:     r = 1'b0;
      C_ALWAYS:    r = 1'b1;
      C_NO_IN:     r = !st.in_valid;
      C_ROM_HIT:   r = st.rom_hit;
      C_ROM_MORE:  r = st.rom_more;
      C_DIV_MORE:  r = st.div_more;
      C_DSEL_MORE: r = st.dsel_more;
      C_ZERO:      r = st.cand_zero;
      C_MULT_MORE: r = st.mult_more;
      C_DOUT_MORE: r = st.dout_more;
      C_OUT_BUSY:  r = st.out_busy;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    word = ucode(step_r);
    if (cond_met(word.cond_a, status)) begin
      step_nxt = word.tgt_a;
    end else if (cond_met(word.cond_b, status)) begin
      step_nxt = word.tgt_b;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_comb begin
    ctrl.op   = word.op;
    ctrl.idle = (step_r == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/pds_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_datapath
// Clock ROM probe, serial divider, candidate evaluator and result registers.
// ----------------------------------------------------------------------------
module pds_datapath import pds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pds_ctrl_t         ctrl,
  output pds_status_t       status,
  input  logic              cfg_wr_en,
  input  logic [REF_W-1:0]  cfg_wr_data,
  pds_in_if.sink            in_ch,
  pds_out_if.source         out_ch
);

  logic [REF_W-1:0]     refclk_r;
  logic [TGT_W-1:0]     target_r;
  logic [ROM_IDX_W-1:0] rom_idx_r;
  logic [DSEL_W-1:0]    dsel_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [REF_W-1:0]     div_quot_r;
  logic [REM_W-1:0]     div_rem_r;
  logic [REF_W-1:0]     q_tab_r [DREF_COUNT];
  logic [REM_W-1:0]     r_tab_r [DREF_COUNT];
  logic [DCNT_W-1:0]    dout_r;
  logic [MULT_W-1:0]    mult_r;
  logic [ACC_W-1:0]     acc_r;
  logic [REM_W-1:0]     acc_rem_r;
  logic [LHS_W-1:0]     lhs_r;
  logic [BEST_W-1:0]    best_r;
  logic [DREF_W-1:0]    b_ref_r;
  logic [MULT_W-1:0]    b_mult_r;
  logic [DOUT_W-1:0]    b_dout_r;
  logic                 res_found_r;
  logic [DREF_W-1:0]    res_ref_r;
  logic [MULT_W-1:0]    res_mult_r;
  logic [DOUT_W-1:0]    res_dout_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [DREF_W-1:0]    out_ref_r;
  logic [MULT_W-1:0]    out_mult_r;
  logic [DOUT_W-1:0]    out_dout_r;

  rom_entry_t           rom_e;
  logic [DREF_W-1:0]    dref;
  logic [REM_W:0]       div_try;
  logic                 div_ge;
  logic [REM_W-1:0]     div_rem_nxt;
  logic [LHS_W-1:0]     acc_ext;
  logic [LHS_W-1:0]     diff;
  logic                 better;
  logic [REM_W:0]       rsum;
  logic                 rwrap;
  logic [ACC_W-1:0]     acc_nxt;
  logic [REM_W-1:0]     acc_rem_nxt;
  logic [MULT_W-1:0]    mult_lo;
  logic [MULT_W-1:0]    mult_top;
  logic [MULT_W-1:0]    mult_hi;
  logic                 found_nxt;
  logic                 out_busy;
  logic                 load_out;
  logic                 dsel_last;

  always_comb begin
    rom_e       = clock_rom(rom_idx_r);
    dref        = DREF_W'(dsel_r) + DREF_W'(DREF_MIN);
    dsel_last   = (dsel_r == DSEL_W'(DREF_COUNT - 1));
    div_try     = {div_rem_r, refclk_r[div_cnt_r]};
    div_ge      = (div_try >= {1'b0, dref});
    div_rem_nxt = div_ge ? REM_W'(div_try - {1'b0, dref}) : div_try[REM_W-1:0];
    acc_ext     = LHS_W'(acc_r);
    diff        = (lhs_r >= acc_ext) ? (lhs_r - acc_ext) : (acc_ext - lhs_r);
    better      = (diff < LHS_W'(best_r));
    rsum        = {1'b0, acc_rem_r} + {1'b0, r_tab_r[dsel_r]};
    rwrap       = (rsum >= {1'b0, dref});
    acc_rem_nxt = rwrap ? REM_W'(rsum - {1'b0, dref}) : rsum[REM_W-1:0];
    acc_nxt     = acc_r + ACC_W'(q_tab_r[dsel_r]) + ACC_W'(rwrap);
    mult_lo     = MULT_W'(dref) * MULT_W'(MULT_LO_FACTOR);
    mult_top    = MULT_W'(dref) * MULT_W'(MULT_HI_FACTOR);
    mult_hi     = (mult_top > MULT_W'(MULT_END - 1)) ? MULT_W'(MULT_END - 1) : mult_top;
    found_nxt   = (best_r < BEST_W'(TOL_KHZ));
    out_busy    = out_valid_r && !out_ch.ready;
    load_out    = (ctrl.op == OP_EMIT) && !out_busy;
  end

  always_comb begin
    status.in_valid  = in_ch.valid;
    status.rom_hit   = (rom_e.khz == target_r);
    status.rom_more  = (rom_idx_r != ROM_IDX_W'(ROM_SIZE - 1));
    status.div_more  = (div_cnt_r != '0);
    status.dsel_more = !dsel_last;
    status.cand_zero = (diff == '0);
    status.mult_more = (mult_r != mult_hi);
    status.dout_more = (dout_r != DCNT_W'(DOUT_END - 1));
    status.out_busy  = out_busy;
  end

  assign in_ch.ready                = ctrl.idle;
  assign out_ch.valid               = out_valid_r;
  assign out_ch.found               = out_found_r;
  assign out_ch.reference_divider   = out_ref_r;
  assign out_ch.feedback_multiplier = out_mult_r;
  assign out_ch.output_divider      = out_dout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refclk_r <= REF_W'(REF_RESET);
    end else if (cfg_wr_en) begin
      refclk_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_ch.valid) begin
          target_r  <= in_ch.target_clock_khz;
          rom_idx_r <= '0;
          best_r    <= BEST_W'(TOL_KHZ);
          b_ref_r   <= '0;
          b_mult_r  <= '0;
          b_dout_r  <= '0;
        end
      end
      OP_ROM: begin
        rom_idx_r <= rom_idx_r + ROM_IDX_W'(1);
        if (status.rom_hit) begin
          res_found_r <= 1'b1;
          res_ref_r   <= rom_e.dref;
          res_mult_r  <= rom_e.mult;
          res_dout_r  <= rom_e.dout;
        end
      end
      OP_DIV_INIT: begin
        dsel_r     <= '0;
        div_cnt_r  <= DIV_CNT_W'(REF_W - 1);
        div_rem_r  <= '0;
        div_quot_r <= '0;
      end
      OP_DIV_STEP: begin
        div_rem_r  <= div_rem_nxt;
        div_quot_r <= {div_quot_r[REF_W-2:0], div_ge};
        div_cnt_r  <= div_cnt_r - DIV_CNT_W'(1);
      end
      OP_DIV_SAVE: begin
        q_tab_r[dsel_r] <= div_quot_r;
        r_tab_r[dsel_r] <= div_rem_r;
        dsel_r          <= dsel_last ? '0 : dsel_r + DSEL_W'(1);
        div_cnt_r       <= DIV_CNT_W'(REF_W - 1);
        div_rem_r       <= '0;
        div_quot_r      <= '0;
      end
      OP_OUT_INIT: begin
        dout_r <= DCNT_W'(DOUT_MIN);
        dsel_r <= '0;
      end
      OP_LHS: begin
        lhs_r <= LHS_W'(target_r) * LHS_W'(dout_r);
      end
      OP_MULT_INIT: begin
        mult_r    <= mult_lo;
        acc_r     <= ACC_W'(refclk_r) * ACC_W'(MULT_LO_FACTOR);
        acc_rem_r <= '0;
      end
      OP_CAND: begin
        if (better) begin
          best_r   <= BEST_W'(diff);
          b_ref_r  <= dref;
          b_mult_r <= mult_r;
          b_dout_r <= DOUT_W'(dout_r);
        end
        acc_r     <= acc_nxt;
        acc_rem_r <= acc_rem_nxt;
        mult_r    <= mult_r + MULT_W'(1);
      end
      OP_DREF_INC: begin
        dsel_r <= dsel_last ? '0 : dsel_r + DSEL_W'(1);
      end
      OP_DOUT_INC: begin
        dout_r <= dout_r + DCNT_W'(1);
      end
      OP_FINISH: begin
        res_found_r <= found_nxt;
        res_ref_r   <= found_nxt ? b_ref_r  : '0;
        res_mult_r  <= found_nxt ? b_mult_r : '0;
        res_dout_r  <= found_nxt ? b_dout_r : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= res_found_r;
      out_ref_r   <= res_ref_r;
      out_mult_r  <= res_mult_r;
      out_dout_r  <= res_dout_r;
    end
  end

endmodule

/* rtl/pll_divider_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_divider_search
// Pixel clock to PLL divider settings: clock ROM lookup, then a search on a miss.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+----------------------------------------------------------
//  in_ch    | in  | target_clock_khz
//  out_ch   | out | found, reference_divider, feedback_multiplier,
//           |     | output_divider
//  cfg_*    | in  | reference_clock_khz write, no read-back
//
//  ROM hit: entries are probed in order up to the match at entry k. Miss:
//  the search time is set by the candidate step, one candidate per cycle through
//  the single difference/compare unit (about 14100 candidates), plus the
//  serial division by each reference divider. A zero difference ends early.
//  One request at a time; the next is taken once the result sits in the
//  output register, which holds it while out_ch.ready is low.
//  Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module pll_divider_search import pds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  pds_in_if.sink           in_ch,
  pds_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [REF_W-1:0] cfg_wr_data
);

  pds_ctrl_t   ctrl;
  pds_status_t status;

  pds_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  pds_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule

/* rtl/pds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks of the PLL divider search, bound to the top level.
// ----------------------------------------------------------------------------
module pds_checker import pds_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [DREF_W-1:0] out_ref,
  input logic [MULT_W-1:0] out_mult,
  input logic [DOUT_W-1:0] out_dout
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_ref)
      && $stable(out_mult) && $stable(out_dout))
    else $error("result changed while stalled");

  // one request in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_ref == '0 && out_mult == '0 && out_dout == '0)
    else $error("miss with nonzero settings");

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |->
      out_ref >= DREF_W'(DREF_MIN) && out_ref <= DREF_W'(DREF_END - 1)
      && out_mult >= MULT_W'(out_ref) * MULT_W'(MULT_LO_FACTOR)
      && out_mult <= MULT_W'(out_ref) * MULT_W'(MULT_HI_FACTOR))
    else $error("settings outside divider limits");

endmodule

bind pll_divider_search pds_checker u_pds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_found (out_ch.found),
  .out_ref   (out_ch.reference_divider),
  .out_mult  (out_ch.feedback_multiplier),
  .out_dout  (out_ch.output_divider)
);

/* tb/sv/pll_divider_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_divider_search_tb
// Self-checking bench for the PLL divider search. A short table of directed
// requests covers the extremes of target and reference clock, clock ROM hits
// and searches with and without a match. The random requests mix clock ROM entries,
// targets built to give an exact divider set, near misses and any 20-bit
// value. Each request is scored against its typed setting or a local search
// model, and the transactions on both sides are throttled at random.
// ----------------------------------------------------------------------------
module pll_divider_search_tb;
  import pds_pkg::*;

  typedef struct packed {
    logic              found;
    logic [DREF_W-1:0] dref;
    logic [MULT_W-1:0] mult;
    logic [DOUT_W-1:0] dout;
  } pll_setting_t;

  typedef struct packed {
    logic [REF_W-1:0] refclk;
    logic [TGT_W-1:0] target;
    logic             typed;
    pll_setting_t     setting;
  } directed_row_t;

  localparam int NUM_DIRECTED   = 22;
  localparam int RANDOM_CHUNKS  = 6;
  localparam int CHUNK_ITEMS    = 12;
  localparam int BURST_ITEMS    = 6;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam pll_setting_t NOT_FOUND = '0;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [REF_W-1:0] cfg_wr_data;

  pds_in_if  in_ch ();
  pds_out_if out_ch ();

  pll_divider_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [REF_W-1:0] ref_clock_khz = REF_W'(REF_RESET);
  int               send_idle_pct = 34;
  int               recv_idle_pct = 61;
  logic             rx_hold = 1'b0;
  bit               holdoff_go = 1'b0;
  int               errors = 0;
  int               n_found = 0;
  int               n_missed = 0;
  int               n_settings = 1;
  pll_setting_t     settings_due [$];

  // reference clock, target, typed, {found, dref, mult, dout}
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    {18'd100000, 20'd148500,  1'b1, 1'b1, 3'd3, 8'd49,  7'd11},
    {18'd100000, 20'd25200,   1'b1, 1'b1, 3'd5, 8'd63,  7'd50},
    {18'd100000, 20'd57284,   1'b1, 1'b1, 3'd4, 8'd55,  7'd24},
    {18'd100000, 20'd0,       1'b1, NOT_FOUND},
    {18'd100000, 20'd1048575, 1'b1, NOT_FOUND},
    {18'd100000, 20'd100000,  1'b0, NOT_FOUND},
    {18'd100000, 20'd200000,  1'b0, NOT_FOUND},
    {18'd100000, 20'd100001,  1'b0, NOT_FOUND},
    {18'd0,      20'd0,       1'b1, 1'b1, 3'd3, 8'd36,  7'd6},
    {18'd0,      20'd166,     1'b1, 1'b1, 3'd3, 8'd36,  7'd6},
    {18'd0,      20'd167,     1'b1, NOT_FOUND},
    {18'd0,      20'd148500,  1'b1, 1'b1, 3'd3, 8'd49,  7'd11},
    {18'd262143, 20'd1048575, 1'b0, NOT_FOUND},
    {18'd262143, 20'd524288,  1'b0, NOT_FOUND},
    {18'd262143, 20'd1,       1'b1, NOT_FOUND},
    {18'd10000,  20'd20000,   1'b0, NOT_FOUND},
    {18'd10000,  20'd33333,   1'b0, NOT_FOUND},
    {18'd10000,  20'd999,     1'b0, NOT_FOUND},
    {18'd200000, 20'd400000,  1'b0, NOT_FOUND},
    {18'd200000, 20'd65000,   1'b1, 1'b1, 3'd3, 8'd39,  7'd20},
    {18'd200000, 20'd1000000, 1'b0, NOT_FOUND},
    {18'd100000, 20'd74250,   1'b1, 1'b1, 3'd3, 8'd49,  7'd22}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rom_entry_t known_clock(input int idx);
    case (idx)
      0:       known_clock = {20'd148500, 3'd3, 8'd49,  7'd11};
      1:       known_clock = {20'd174500, 3'd3, 8'd89,  7'd17};
      2:       known_clock = {20'd181250, 3'd4, 8'd58,  7'd8};
      3:       known_clock = {20'd146250, 3'd5, 8'd117, 7'd16};
      4:       known_clock = {20'd135000, 3'd4, 8'd54,  7'd10};
      5:       known_clock = {20'd108000, 3'd5, 8'd81,  7'd15};
      6:       known_clock = {20'd106500, 3'd4, 8'd81,  7'd19};
      7:       known_clock = {20'd88750,  3'd5, 8'd71,  7'd16};
      8:       known_clock = {20'd83500,  3'd5, 8'd71,  7'd17};
      9:       known_clock = {20'd71000,  3'd5, 8'd71,  7'd20};
      10:      known_clock = {20'd74250,  3'd3, 8'd49,  7'd22};
      11:      known_clock = {20'd78750,  3'd5, 8'd63,  7'd16};
      12:      known_clock = {20'd75000,  3'd4, 8'd87,  7'd29};
      13:      known_clock = {20'd65000,  3'd3, 8'd39,  7'd20};
      14:      known_clock = {20'd51200,  3'd5, 8'd64,  7'd25};
      15:      known_clock = {20'd57284,  3'd4, 8'd55,  7'd24};
      16:      known_clock = {20'd49500,  3'd5, 8'd99,  7'd40};
      17:      known_clock = {20'd50000,  3'd4, 8'd88,  7'd44};
      18:      known_clock = {20'd40000,  3'd3, 8'd36,  7'd30};
      19:      known_clock = {20'd36000,  3'd4, 8'd72,  7'd50};
      20:      known_clock = {20'd31500,  3'd5, 8'd63,  7'd40};
      21:      known_clock = {20'd30240,  3'd4, 8'd75,  7'd62};
      22:      known_clock = {20'd27000,  3'd4, 8'd54,  7'd50};
      23:      known_clock = {20'd25175,  3'd5, 8'd107, 7'd85};
      24:      known_clock = {20'd25200,  3'd5, 8'd63,  7'd50};
      default: known_clock = '0;
    endcase
  endfunction

  // ROM probe, then output divider / reference divider / multiplier sweep
  function automatic pll_setting_t search_pll_setting(input logic [TGT_W-1:0] target,
                                                      input logic [REF_W-1:0] refclk);
    pll_setting_t    best_set;
    rom_entry_t      e;
    longint unsigned lhs, rhs, diff, best;
    bit              zero_hit;
    best_set = NOT_FOUND;
    for (int i = 0; i < ROM_SIZE; i++) begin
      e = known_clock(i);
      if (e.khz == target) return {1'b1, e.dref, e.mult, e.dout};
    end
    best = TOL_KHZ;
    zero_hit = 1'b0;
    for (int dout = DOUT_MIN; dout < DOUT_END && !zero_hit; dout++)
      for (int dref = DREF_MIN; dref < DREF_END && !zero_hit; dref++)
        for (int mult = MULT_LO_FACTOR * dref;
             mult <= MULT_HI_FACTOR * dref && mult < MULT_END && !zero_hit; mult++) begin
          lhs  = 64'(target) * 64'(dout);
          rhs  = 64'(refclk) * 64'(mult) / 64'(dref);
          diff = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
          if (diff < best) begin
            best     = diff;
            best_set = {1'b1, DREF_W'(dref), MULT_W'(mult), DOUT_W'(dout)};
            zero_hit = (diff == 0);
          end
        end
    return best_set;
  endfunction

  function automatic logic [TGT_W-1:0] exact_target(input logic [REF_W-1:0] refclk);
    longint unsigned rhs, quot;
    int              dout, dref, mult;
    quot = 0;
    for (int t = 0; t < 32; t++) begin
      dout = $urandom_range(DOUT_END - 1, DOUT_MIN);
      dref = $urandom_range(DREF_END - 1, DREF_MIN);
      mult = $urandom_range(MULT_HI_FACTOR * dref, MULT_LO_FACTOR * dref);
      rhs  = 64'(refclk) * 64'(mult) / 64'(dref);
      quot = rhs / 64'(dout);
      if (rhs % 64'(dout) == 0 && quot < (64'd1 << TGT_W)) return TGT_W'(quot);
    end
    return TGT_W'(quot);
  endfunction

  function automatic logic [TGT_W-1:0] random_target(input logic [REF_W-1:0] refclk,
                                                     input bit rom_only);
    rom_entry_t e;
    int         kind;
    e = known_clock($urandom_range(ROM_SIZE - 1));
    kind = rom_only ? 0 : $urandom_range(99);
    if (kind < 35) return e.khz;
    if (kind < 70) return exact_target(refclk);
    if (kind < 78) return $urandom_range(1) ? e.khz + 1'b1 : e.khz - 1'b1;
    if (kind < 88) return TGT_W'($urandom_range(1000000));
    return TGT_W'($urandom);
  endfunction

  task automatic send_request(input logic [TGT_W-1:0] target, input logic typed,
                              input pll_setting_t typed_setting);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.target_clock_khz <= target;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    settings_due.push_back(typed ? typed_setting : search_pll_setting(target, ref_clock_khz));
  endtask

  // only while the block is idle: every result back
  task automatic write_ref_clock(input logic [REF_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (settings_due.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    ref_clock_khz = value;
    n_settings++;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin : stimulus
    logic [REF_W-1:0] chunk_ref;
    in_ch.valid            <= 1'b0;
    in_ch.target_clock_khz <= '0;
    cfg_wr_en              <= 1'b0;
    cfg_wr_data            <= '0;
    rst_n                  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].refclk != ref_clock_khz)
        write_ref_clock(directed_rows[i].refclk);
      send_request(directed_rows[i].target, directed_rows[i].typed,
                   directed_rows[i].setting);
    end

    // ROM hits while the result side is held off
    holdoff_go = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++)
      send_request(random_target(ref_clock_khz, 1'b1), 1'b0, NOT_FOUND);

    for (int c = 0; c < RANDOM_CHUNKS; c++) begin
      send_idle_pct = (c < 2) ? 34 : (c < 4) ? 61 : 0;
      recv_idle_pct = (c < 2) ? 61 : (c < 4) ? 34 : 0;
      case (c)
        0, 3:    chunk_ref = REF_W'(REF_RESET);
        2:       chunk_ref = REF_W'($urandom);
        default: chunk_ref = REF_W'($urandom_range(200000, 10000));
      endcase
      write_ref_clock(chunk_ref);
      for (int k = 0; k < CHUNK_ITEMS; k++)
        send_request(random_target(ref_clock_khz, 1'b0), 1'b0, NOT_FOUND);
    end
    in_ch.valid <= 1'b0;

    while (settings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d results checked over %0d reference clock settings: %0d found, %0d none",
             n_found + n_missed, n_settings, n_found, n_missed);
    $display("covered ROM hits, exact and near targets, field extremes, %0d-cycle hold-off",
             HOLDOFF_CYCLES);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : result_ready
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : rx_holdoff
    wait (holdoff_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : result_check
    pll_setting_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (settings_due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got %0d/%0d/%0d/%0d", $time,
                 out_ch.found, out_ch.reference_divider, out_ch.feedback_multiplier,
                 out_ch.output_divider);
        errors++;
      end else begin
        want = settings_due.pop_front();
        check_field("found", want.found, out_ch.found);
        check_field("reference_divider", want.dref, out_ch.reference_divider);
        check_field("feedback_multiplier", want.mult, out_ch.feedback_multiplier);
        check_field("output_divider", want.dout, out_ch.output_divider);
        if (want.found) n_found++;
        else n_missed++;
      end
    end
  end

  initial begin : watchdog
    #100_000_000;
    $display("timeout with %0d results outstanding", settings_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
rtl/pds_pkg.sv
rtl/pds_if.sv
rtl/pds_sequencer.sv
rtl/pds_datapath.sv
rtl/pll_divider_search.sv
rtl/pds_checker.sv
tb/sv/pll_divider_search_tb.sv
